[hw/rtl/albd_pkg.sv]
package albd_pkg;

   // button count and field widths
   localparam int NUM_BUTTONS = 5;
   localparam int SAMPLE_W    = 12;
   localparam int WINDOW_W    = 2 * SAMPLE_W;
   localparam int COUNT_W     = 6;
   localparam int BTN_IDX_W   = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
   localparam int CSR_IDX_W   = $clog2(NUM_BUTTONS + 2);
   localparam int CSR_DATA_W  = WINDOW_W;

   // register indexes: windows first, then the two levels
   localparam logic [CSR_IDX_W-1:0] REG_PRESS_LEVEL   = CSR_IDX_W'(NUM_BUTTONS);
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE_FLOOR = CSR_IDX_W'(NUM_BUTTONS + 1);

   // level reset values
   localparam logic [COUNT_W-1:0] PRESS_LEVEL_RESET   = COUNT_W'(50);
   localparam logic [COUNT_W-1:0] RELEASE_FLOOR_RESET = COUNT_W'(10);

   typedef logic [WINDOW_W-1:0]                   window_type;
   typedef logic [NUM_BUTTONS-1:0][WINDOW_W-1:0]  window_array_type;
   typedef logic [NUM_BUTTONS-1:0]                button_mask_type;

   typedef struct packed {
      window_array_type     windows;
      logic [COUNT_W-1:0]   press_level;
      logic [COUNT_W-1:0]   release_floor;
   } cfg_type;

   typedef struct packed {
      logic                 hit;
      logic [BTN_IDX_W-1:0] index;
   } match_type;

   // window reset values: (0,50) (100,200) (300,450) (600,750) (1400,1500)
   function automatic window_type window_reset(input int i);
      window_type w;
      case (i)
         0:       w = WINDOW_W'(204800);
         1:       w = WINDOW_W'(819300);
         2:       w = WINDOW_W'(1843500);
         3:       w = WINDOW_W'(3072600);
         4:       w = WINDOW_W'(6145400);
         default: w = '0;
      endcase
      return w;
   endfunction

endpackage

[hw/rtl/albd_if.sv]
interface albd_req_if;
   import albd_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface albd_rsp_if;
   import albd_pkg::*;
   logic            valid;
   logic            ready;
   button_mask_type held_buttons;
   button_mask_type pressed_buttons;

   modport source (output valid, output held_buttons, output pressed_buttons, input ready);
   modport sink   (input valid, input held_buttons, input pressed_buttons, output ready);
endinterface

interface albd_csr_if;
   import albd_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/albd_cfg_regs.sv]
module albd_cfg_regs (
   input  logic              clock,
   input  logic              reset,
   albd_csr_if.sink          csr_bus,
   output albd_pkg::cfg_type cfg
);
   import albd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // writes are always taken
   assign csr_bus.ready = 1'b1;

   // register write decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         if (csr_bus.index < CSR_IDX_W'(NUM_BUTTONS)) begin
            cfg_in.windows[csr_bus.index[BTN_IDX_W-1:0]] = csr_bus.data[WINDOW_W-1:0];
         end else if (csr_bus.index == REG_PRESS_LEVEL) begin
            cfg_in.press_level = csr_bus.data[COUNT_W-1:0];
         end else if (csr_bus.index == REG_RELEASE_FLOOR) begin
            cfg_in.release_floor = csr_bus.data[COUNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            cfg_ff.windows[i] <= window_reset(i);
         end
         cfg_ff.press_level   <= PRESS_LEVEL_RESET;
         cfg_ff.release_floor <= RELEASE_FLOOR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

[hw/rtl/albd_match.sv]
module albd_match (
   input  logic [albd_pkg::SAMPLE_W-1:0] sample,
   input  albd_pkg::cfg_type             cfg,
   output albd_pkg::match_type           match
);
   import albd_pkg::*;

   button_mask_type in_window;

   // open window compare per button
   always_comb begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         in_window[i] = (cfg.windows[i][SAMPLE_W-1:0] < sample) &&
                        (sample < cfg.windows[i][WINDOW_W-1:SAMPLE_W]);
      end
   end

   // lowest matching button wins
   always_comb begin
      match.hit   = 1'b0;
      match.index = '0;
      for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
         if (in_window[i]) begin
            match.hit   = 1'b1;
            match.index = BTN_IDX_W'(i);
         end
      end
   end
endmodule

[hw/rtl/albd_counters.sv]
module albd_counters (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  albd_pkg::match_type       match,
   input  albd_pkg::cfg_type         cfg,
   output albd_pkg::button_mask_type held_next,
   output albd_pkg::button_mask_type pressed_next
);
   import albd_pkg::*;

   logic [COUNT_W-1:0] counter_ff [NUM_BUTTONS];
   logic [COUNT_W-1:0] counter_in [NUM_BUTTONS];
   button_mask_type    held_ff;
   button_mask_type    held_in;

   // per button counter lane: count up on its own match, decay when nothing matches
   always_comb begin
      held_in = held_ff;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         counter_in[i] = counter_ff[i];
         if (match.hit) begin
            if (match.index == BTN_IDX_W'(i)) begin
               if (counter_ff[i] >= cfg.press_level) begin
                  counter_in[i] = cfg.press_level;
               end else begin
                  counter_in[i] = counter_ff[i] + COUNT_W'(1);
               end
               held_in[i] = (counter_in[i] >= cfg.press_level);
            end
         end else begin
            if (counter_ff[i] <= cfg.release_floor) begin
               counter_in[i] = cfg.release_floor;
            end else begin
               counter_in[i] = counter_ff[i] - COUNT_W'(1);
            end
            held_in[i] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            counter_ff[i] <= '0;
         end
         held_ff <= '0;
      end else if (enable) begin
         counter_ff <= counter_in;
         held_ff    <= held_in;
      end
   end

   // held_ff is last tick's held set
   assign held_next    = held_in;
   assign pressed_next = held_in & ~held_ff;
endmodule

[hw/rtl/adc_ladder_button_debouncer_core.sv]
// Path: a request is accepted into the sample register and is answered once it
// moves on into the response register.
// Throughput: one request per cycle while the response side is not stalled;
// the window compare and counter update sit in a single stage between those two registers.
// Reset: synchronous; counters and held bits clear, windows and levels take
// their default values, both pipeline stages empty.
module adc_ladder_button_debouncer_core (
   input logic       clock,
   input logic       reset,
   albd_req_if.sink  req_bus,
   albd_rsp_if.source rsp_bus,
   albd_csr_if.sink  csr_bus
);
   import albd_pkg::*;

   cfg_type             cfg;
   match_type           match;
   button_mask_type     held_next;
   button_mask_type     pressed_next;

   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic [SAMPLE_W-1:0] s1_sample_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   button_mask_type     rsp_held_ff;
   button_mask_type     rsp_pressed_ff;
   logic                advance;
   logic                req_take;

   albd_cfg_regs u_cfg_regs (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   albd_match u_match (
      .sample (s1_sample_ff),
      .cfg    (cfg),
      .match  (match)
   );

   albd_counters u_counters (
      .clock        (clock),
      .reset        (reset),
      .enable       (advance),
      .match        (match),
      .cfg          (cfg),
      .held_next    (held_next),
      .pressed_next (pressed_next)
   );

   // pipeline flow control
   assign advance       = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || !rsp_valid_ff || rsp_bus.ready;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_sample_ff <= req_bus.sample;
      end
      if (advance) begin
         rsp_held_ff    <= held_next;
         rsp_pressed_ff <= pressed_next;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.held_buttons    = rsp_held_ff;
   assign rsp_bus.pressed_buttons = rsp_pressed_ff;
endmodule

[hw/rtl/albd_checker.sv]
module albd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input albd_pkg::button_mask_type       rsp_held,
   input albd_pkg::button_mask_type       rsp_pressed
);
   import albd_pkg::*;

   // a newly pressed button is always among the held ones
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_pressed & ~rsp_held) == '0))
      else $error("pressed bit without held bit");

   // reset empties the response stage
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_held) && $stable(rsp_pressed))
      else $error("response payload changed while stalled");
endmodule

bind adc_ladder_button_debouncer_core albd_checker u_albd_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_held    (rsp_bus.held_buttons),
   .rsp_pressed (rsp_bus.pressed_buttons)
);
